@@ src/mdte_pkg.sv @@
// Package: shared types, codes and constants of the MIDI drum track event encoder.
`default_nettype none
package mdte_pkg;

  localparam int PAD_COUNT = 64;
  localparam int PAD_W     = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_NOTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPO_BPM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_QN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_NOTE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOTE_LENGTH  = 3'd5;

  localparam logic [25:0] TEMPO_US_NUM = 26'd60000000;
  localparam logic [27:0] DELTA_MAX    = 28'hFFFFFFF;
  localparam logic [7:0]  NOTE_ON_CH10  = 8'h99;
  localparam logic [7:0]  NOTE_OFF_CH10 = 8'h89;
  localparam logic [7:0]  META_PREFIX   = 8'hFF;
  localparam logic [7:0]  META_TEMPO    = 8'h51;
  localparam logic [7:0]  META_EOT      = 8'h2F;

  typedef enum logic [1:0] {CMD_START, CMD_NOTE, CMD_END} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [23:0] tempo_us;
    logic [27:0] delta;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] length;
  } cmd_t;

  typedef enum logic [2:0] {F_IDLE, F_MUL1, F_MUL2, F_MUL3, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_FIXED, B_DVLQ, B_ON, B_LVLQ, B_OFF} back_state_t;

  // index of the most significant non-empty 7-bit group
  function automatic logic [1:0] vlq_top(input logic [27:0] v);
    logic [1:0] g;
    if (v[27:21] != 7'd0) g = 2'd3;
    else if (v[20:14] != 7'd0) g = 2'd2;
    else if (v[13:7] != 7'd0) g = 2'd1;
    else g = 2'd0;
    return g;
  endfunction

  function automatic logic [7:0] vlq_byte(input logic [27:0] v, input logic [1:0] g);
    logic [6:0] grp;
    case (g)
      2'd0: grp = v[6:0];
      2'd1: grp = v[13:7];
      2'd2: grp = v[20:14];
      default: grp = v[27:21];
    endcase
    return {(g != 2'd0), grp};
  endfunction

endpackage
`default_nettype wire

@@ src/mdte_ifs.sv @@
// Interfaces: input item channel, byte output channel and register write channel.
`default_nettype none
interface mdte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [30:0] frame_position;
  modport source (output valid, opcode, frame_position, input ready);
  modport sink (input valid, opcode, frame_position, output ready);
endinterface

interface mdte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

interface mdte_cfg_if import mdte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/midi_drum_track_event_encoder.sv @@
// Top level: front computes each event, queue decouples, back streams the bytes.
// A note item runs two multiply steps, a setup step, a 58-step restoring divider
// and one push in the front; a start item only the shared divider and the push;
// an end item only the push. The front takes a new item once the last is pushed;
// the back drains up to 13 bytes per item in parallel, one per cycle unless stalled.
// Reset (rst, synchronous) restores register defaults and clears queue and state.
`default_nettype none
module midi_drum_track_event_encoder import mdte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mdte_in_if.sink    in_ch,
  mdte_cfg_if.sink   cfg,
  mdte_out_if.source out_ch
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;

  mdte_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  mdte_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  mdte_back u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_ch(out_ch)
  );

endmodule
`default_nettype wire

@@ src/mdte_front.sv @@
// Front: config registers, item accept, tick/tempo arithmetic and command build.
`default_nettype none
module mdte_front import mdte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mdte_in_if.sink    in_ch,
  mdte_cfg_if.sink   cfg,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_data
);

  logic [17:0] frame_rate;
  logic [9:0]  tempo_bpm;
  logic [14:0] ticks_per_quarter;
  logic [6:0]  start_note;
  logic [6:0]  note_velocity;
  logic [15:0] note_length;

  logic [39:0]      prev_end;
  logic [PAD_W-1:0] pad;

  front_state_t state, state_next;
  cmd_kind_t    kind;
  logic [30:0]  frames;
  logic [55:0]  prod;
  logic [23:0]  den;
  logic [57:0]  dvd;
  logic [24:0]  dvs;
  logic [24:0]  rem;
  logic [57:0]  quot;
  logic [5:0]   dcnt;

  logic        in_acc;
  logic [25:0] remsh;
  logic        ge;
  logic [57:0] diff;
  logic        ahead;
  logic [58:0] end_sum;
  logic [17:0] rate_eff;
  logic [9:0]  bpm_eff;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = (state == F_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rate_eff    = (frame_rate == 18'd0) ? 18'd1 : frame_rate;
  assign bpm_eff     = (tempo_bpm == 10'd0) ? 10'd1 : tempo_bpm;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate        <= 18'd44100;
      tempo_bpm         <= 10'd120;
      ticks_per_quarter <= 15'd96;
      start_note        <= 7'd36;
      note_velocity     <= 7'd100;
      note_length       <= 16'd24;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SAMPLE_RATE:  frame_rate        <= cfg.data;
        REG_TEMPO_BPM:    tempo_bpm         <= cfg.data[9:0];
        REG_TICKS_PER_QN: ticks_per_quarter <= cfg.data[14:0];
        REG_START_NOTE:   start_note        <= cfg.data[6:0];
        REG_VELOCITY:     note_velocity     <= cfg.data[6:0];
        REG_NOTE_LENGTH:  note_length       <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_acc) begin
          case (in_ch.opcode)
            OP_START: state_next = F_DIV;
            OP_NOTE:  state_next = F_MUL1;
            OP_END:   state_next = F_PUSH;
            default:  state_next = F_IDLE;
          endcase
        end
      end
      F_MUL1: state_next = F_MUL2;
      F_MUL2: state_next = F_MUL3;
      F_MUL3: state_next = F_DIV;
      F_DIV:  if (dcnt == 6'd0) state_next = F_PUSH;
      F_PUSH: if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // one restoring division step per cycle
  assign remsh = {rem, dvd[57]};
  assign ge    = (remsh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_acc) begin
          frames <= in_ch.frame_position;
          case (in_ch.opcode)
            OP_START: kind <= CMD_START;
            OP_NOTE:  kind <= CMD_NOTE;
            default:  kind <= CMD_END;
          endcase
          dvd  <= 58'(TEMPO_US_NUM);
          dvs  <= 25'(bpm_eff);
          rem  <= 25'd0;
          dcnt <= 6'd57;
        end
      end
      F_MUL1: begin
        prod <= 56'(41'(frames) * 41'(tempo_bpm));
        den  <= 24'(rate_eff) * 24'd60;
      end
      F_MUL2: prod <= 56'(prod[40:0]) * 56'(ticks_per_quarter);
      F_MUL3: begin
        dvd  <= {prod, 1'b0} + 58'(den);
        dvs  <= {den, 1'b0};
        rem  <= 25'd0;
        dcnt <= 6'd57;
      end
      F_DIV: begin
        rem  <= ge ? 25'(remsh - {1'b0, dvs}) : remsh[24:0];
        quot <= {quot[56:0], ge};
        dvd  <= {dvd[56:0], 1'b0};
        dcnt <= dcnt - 6'd1;
      end
      default: ;
    endcase
  end

  assign diff    = quot - {18'd0, prev_end};
  assign ahead   = (quot > {18'd0, prev_end});
  assign end_sum = {1'b0, quot} + 59'(note_length);

  always_comb begin
    push_valid         = (state == F_PUSH);
    push_data.kind     = kind;
    push_data.tempo_us = (quot > 58'hFFFFFF) ? 24'hFFFFFF : quot[23:0];
    if (!ahead) push_data.delta = 28'd0;
    else if (diff > 58'(DELTA_MAX)) push_data.delta = DELTA_MAX;
    else push_data.delta = diff[27:0];
    push_data.note     = start_note + 7'(pad);
    push_data.velocity = note_velocity;
    push_data.length   = note_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_end <= 40'd0;
      pad      <= '0;
    end else if (push_valid && push_ready) begin
      case (kind)
        CMD_START: begin
          prev_end <= 40'd0;
          pad      <= '0;
        end
        CMD_NOTE: begin
          prev_end <= (end_sum > 59'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : end_sum[39:0];
          pad      <= (pad == PAD_W'(PAD_COUNT - 1)) ? '0 : pad + PAD_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/mdte_queue.sv @@
// Two-entry command queue between the front and the back.
`default_nettype none
module mdte_queue import mdte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t       mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/mdte_back.sv @@
// Back: serializes one command into track bytes through an output register.
`default_nettype none
module mdte_back import mdte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  cmd_t       pop_data,
  mdte_out_if.source out_ch
);

  back_state_t state, state_next;
  cmd_t        cmd;
  logic [2:0]  cnt, cnt_next;
  logic        ovalid;
  logic [7:0]  obyte;
  logic        olast;
  logic        emit;
  logic [7:0]  byte_cur;
  logic        last_cur;

  assign out_ch.valid     = ovalid;
  assign out_ch.out_byte  = obyte;
  assign out_ch.last_byte = olast;
  assign pop_ready        = (state == B_IDLE);
  assign emit             = (state != B_IDLE) && (!ovalid || out_ch.ready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    byte_cur   = 8'h00;
    last_cur   = 1'b0;
    case (state)
      B_IDLE: begin
        if (pop_valid) begin
          if (pop_data.kind == CMD_NOTE) begin
            state_next = B_DVLQ;
            cnt_next   = {1'b0, vlq_top(pop_data.delta)};
          end else begin
            state_next = B_FIXED;
            cnt_next   = 3'd0;
          end
        end
      end
      B_FIXED: begin
        if (cmd.kind == CMD_START) begin
          case (cnt)
            3'd0: byte_cur = 8'h00;
            3'd1: byte_cur = META_PREFIX;
            3'd2: byte_cur = META_TEMPO;
            3'd3: byte_cur = 8'h03;
            3'd4: byte_cur = cmd.tempo_us[23:16];
            3'd5: byte_cur = cmd.tempo_us[15:8];
            default: byte_cur = cmd.tempo_us[7:0];
          endcase
          last_cur = (cnt == 3'd6);
        end else begin
          case (cnt)
            3'd1: byte_cur = META_PREFIX;
            3'd2: byte_cur = META_EOT;
            default: byte_cur = 8'h00;
          endcase
          last_cur = (cnt == 3'd3);
        end
        if (emit) begin
          cnt_next = cnt + 3'd1;
          if (last_cur) state_next = B_IDLE;
        end
      end
      B_DVLQ: begin
        byte_cur = vlq_byte(cmd.delta, cnt[1:0]);
        if (emit) begin
          if (cnt == 3'd0) state_next = B_ON;
          else cnt_next = cnt - 3'd1;
        end
      end
      B_ON: begin
        case (cnt)
          3'd0: byte_cur = NOTE_ON_CH10;
          3'd1: byte_cur = {1'b0, cmd.note};
          default: byte_cur = {1'b0, cmd.velocity};
        endcase
        if (emit) begin
          if (cnt == 3'd2) begin
            state_next = B_LVLQ;
            cnt_next   = {1'b0, vlq_top(28'(cmd.length))};
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      B_LVLQ: begin
        byte_cur = vlq_byte(28'(cmd.length), cnt[1:0]);
        if (emit) begin
          if (cnt == 3'd0) state_next = B_OFF;
          else cnt_next = cnt - 3'd1;
        end
      end
      B_OFF: begin
        case (cnt)
          3'd0: byte_cur = NOTE_OFF_CH10;
          3'd1: byte_cur = {1'b0, cmd.note};
          default: byte_cur = 8'h00;
        endcase
        last_cur = (cnt == 3'd2);
        if (emit) begin
          if (last_cur) state_next = B_IDLE;
          else cnt_next = cnt + 3'd1;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      cnt    <= 3'd0;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (emit) ovalid <= 1'b1;
      else if (out_ch.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) cmd <= pop_data;
    if (emit) begin
      obyte <= byte_cur;
      olast <= last_cur;
    end
  end

endmodule
`default_nettype wire

@@ verif/midi_drum_track_event_encoder_checker.sv @@
// Checker: watches the channels, predicts the track bytes and compares them.
`timescale 1ns / 1ps
module midi_drum_track_event_encoder_checker import mdte_pkg::*; (
  input  logic clk,
  input  logic rst,
  mdte_in_if   in_ch,
  mdte_cfg_if  cfg,
  mdte_out_if  out_ch,
  output int   errors,
  output int   pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  localparam logic [27:0] VLQ_MAX = 28'hFFFFFFF;
  localparam logic [39:0] TICK_MAX = 40'hFFFFFFFFFF;

  track_byte_t byte_q[$];
  logic [7:0]  event_bytes[16];
  int          event_len;

  logic [17:0] rate_reg;
  logic [9:0]  bpm_reg;
  logic [14:0] ppq_reg;
  logic [6:0]  first_pad_reg;
  logic [6:0]  velocity_reg;
  logic [15:0] length_reg;
  logic [39:0] last_off_tick;
  logic [PAD_W-1:0] pad_idx;

  task automatic add_byte(input logic [7:0] b);
    event_bytes[event_len] = b;
    event_len++;
  endtask

  task automatic add_vlq(input logic [27:0] v);
    int groups;
    if (v[27:21] != 0) groups = 4;
    else if (v[20:14] != 0) groups = 3;
    else if (v[13:7] != 0) groups = 2;
    else groups = 1;
    for (int g = groups - 1; g >= 0; g--) add_byte({g > 0, v[7*g +: 7]});
  endtask

  task automatic encode_event(input logic [1:0] op, input logic [30:0] frames);
    logic [63:0] bpm, us, den, num, tick, gap, off;
    logic [6:0]  note;
    track_byte_t tb;
    event_len = 0;
    case (op)
      OP_START: begin
        bpm = (bpm_reg == 0) ? 64'd1 : 64'(bpm_reg);
        us = 64'd60000000 / bpm;
        if (us > 64'hFFFFFF) us = 64'hFFFFFF;
        add_byte(8'h00); add_byte(META_PREFIX); add_byte(META_TEMPO); add_byte(8'h03);
        add_byte(us[23:16]); add_byte(us[15:8]); add_byte(us[7:0]);
        last_off_tick = '0;
        pad_idx = '0;
      end
      OP_NOTE: begin
        den = 64'd60 * ((rate_reg == 0) ? 64'd1 : 64'(rate_reg));
        num = 64'(frames) * 64'(bpm_reg) * 64'(ppq_reg);
        tick = (2 * num + den) / (2 * den);
        note = first_pad_reg + 7'(pad_idx);
        gap = (tick > 64'(last_off_tick)) ? tick - 64'(last_off_tick) : 64'd0;
        if (gap > 64'(VLQ_MAX)) gap = 64'(VLQ_MAX);
        add_vlq(gap[27:0]);
        add_byte(NOTE_ON_CH10); add_byte({1'b0, note}); add_byte({1'b0, velocity_reg});
        add_vlq(28'(length_reg));
        add_byte(NOTE_OFF_CH10); add_byte({1'b0, note}); add_byte(8'h00);
        off = tick + 64'(length_reg);
        last_off_tick = (off > 64'(TICK_MAX)) ? TICK_MAX : off[39:0];
        pad_idx = (pad_idx == PAD_W'(PAD_COUNT - 1)) ? '0 : pad_idx + PAD_W'(1);
      end
      OP_END: begin
        add_byte(8'h00); add_byte(META_PREFIX); add_byte(META_EOT); add_byte(8'h00);
      end
      default: ;
    endcase
    for (int i = 0; i < event_len; i++) begin
      tb = {event_bytes[i], i == event_len - 1};
      byte_q.insert(byte_q.size(), tb);
    end
  endtask

  always @(posedge clk) begin
    track_byte_t want;
    if (rst) begin
      rate_reg = 18'd44100;
      bpm_reg = 10'd120;
      ppq_reg = 15'd96;
      first_pad_reg = 7'd36;
      velocity_reg = 7'd100;
      length_reg = 16'd24;
      last_off_tick = '0;
      pad_idx = '0;
      byte_q.delete();
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SAMPLE_RATE:  rate_reg = cfg.data[17:0];
          REG_TEMPO_BPM:    bpm_reg = cfg.data[9:0];
          REG_TICKS_PER_QN: ppq_reg = cfg.data[14:0];
          REG_START_NOTE:   first_pad_reg = cfg.data[6:0];
          REG_VELOCITY:     velocity_reg = cfg.data[6:0];
          REG_NOTE_LENGTH:  length_reg = cfg.data[15:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (byte_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected beat: byte %h last %b", out_ch.out_byte, out_ch.last_byte);
        end else begin
          want = byte_q.pop_front();
          if (want.data !== out_ch.out_byte || want.last !== out_ch.last_byte) begin
            errors++;
            if (errors <= 10)
              $display("beat mismatch: expected byte %h last %b, got byte %h last %b",
                       want.data, want.last, out_ch.out_byte, out_ch.last_byte);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) encode_event(in_ch.opcode, in_ch.frame_position);
    end
    pending = byte_q.size();
  end

endmodule

@@ verif/midi_drum_track_event_encoder_test.sv @@
// Testbench top: clock, reset, stimulus, handshake idling and the verdict.
`timescale 1ns / 1ps
module midi_drum_track_event_encoder_test;
  import mdte_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, cycles = 0, sent = 0;
  int   send_idle = 36, recv_idle = 86;
  logic [30:0] frame_pos;

  mdte_in_if  in_ch();
  mdte_out_if out_ch();
  mdte_cfg_if cfg();

  midi_drum_track_event_encoder dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .cfg(cfg.sink), .out_ch(out_ch.source)
  );

  midi_drum_track_event_encoder_checker checker_i (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg), .out_ch(out_ch),
    .errors(errors), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [30:0] frames);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.frame_position <= frames;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (sent == 45) begin
      send_idle = 86; recv_idle = 36;
    end else if (sent == 90) begin
      send_idle = 0; recv_idle = 0;
    end
  endtask

  // hold until the byte stream has drained and the front is done
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [17:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [17:0] rate, bpm, ppq, first_pad, vel, len);
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_TEMPO_BPM, bpm);
    write_reg(REG_TICKS_PER_QN, ppq);
    write_reg(REG_START_NOTE, first_pad);
    write_reg(REG_VELOCITY, vel);
    write_reg(REG_NOTE_LENGTH, len);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_item(OP_START, 31'($urandom));
      frame_pos = '0;
    end else if (pick < 14) send_item(OP_END, 31'($urandom));
    else if (pick < 18) send_item(OP_UNUSED, 31'($urandom));
    else if (pick < 26) send_item(OP_NOTE, 31'($urandom));
    else begin
      // mostly ascending hits, now and then a step back in time
      if ($urandom_range(9) == 0) frame_pos = frame_pos - 31'($urandom_range(20000));
      else frame_pos = frame_pos + 31'($urandom_range(($urandom_range(3) == 0) ? 2000000 : 30000));
      send_item(OP_NOTE, frame_pos);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_START;
    in_ch.frame_position = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_SAMPLE_RATE;
    cfg.data = '0;
    frame_pos = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: start, notes, a hit behind the last note end, unused op, end
    send_item(OP_START, '0);
    send_item(OP_NOTE, 31'd0);
    send_item(OP_NOTE, 31'd44100);
    send_item(OP_NOTE, 31'd40000);
    send_item(OP_NOTE, 31'h7FFFFFFF);
    send_item(OP_UNUSED, 31'h7FFFFFFF);
    send_item(OP_NOTE, 31'h2AAAAAAA);
    send_item(OP_NOTE, 31'h55555555);
    send_item(OP_END, '0);
    wait_quiet();
    write_reg(REG_SPARE, 18'h3FFFF);
    write_all(18'd192000, 18'd999, 18'd32767, 18'd127, 18'd127, 18'd65535);
    send_item(OP_START, '0);
    send_item(OP_NOTE, 31'd1);
    send_item(OP_NOTE, 31'h7FFFFFFF);
    send_item(OP_END, '0);
    wait_quiet();
    // slowest tempo saturates the tempo value; frames at the top overflow the end tick
    write_all(18'd1, 18'd1, 18'd1, 18'd0, 18'd0, 18'd0);
    send_item(OP_START, '0);
    send_item(OP_NOTE, 31'd30);
    send_item(OP_NOTE, 31'd29);
    wait_quiet();
    write_all(18'd1, 18'd999, 18'd32767, 18'd64, 18'd1, 18'd65535);
    send_item(OP_NOTE, 31'h7FFFFFFF);
    send_item(OP_NOTE, 31'h7FFFFFFF);
    wait_quiet();
    // zero rate, zero tempo and zero ticks per quarter note
    write_all(18'd0, 18'd0, 18'd0, 18'd5, 18'd64, 18'd127);
    send_item(OP_START, '0);
    send_item(OP_NOTE, 31'd12345);
    send_item(OP_END, '0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      case (ph)
        0: write_all(18'd44100, 18'd120, 18'd96, 18'd36, 18'd100, 18'd24);
        1: write_all(18'h3FFFF, 18'd1023, 18'd32767, 18'd100, 18'd1, 18'd16383);
        2: write_all(18'd48000, 18'd2, 18'd480, 18'd120, 18'd90, 18'd128);
        default: write_all(18'($urandom_range(192000, 1)), 18'($urandom_range(999, 1)),
                           18'($urandom_range(32767, 1)), 18'($urandom_range(127)),
                           18'($urandom_range(127)), 18'($urandom_range(65535)));
      endcase
      for (int i = 0; i < 18; i++) random_item();
    end

    wait_quiet();
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
src/mdte_pkg.sv
src/mdte_ifs.sv
src/mdte_front.sv
src/mdte_queue.sv
src/mdte_back.sv
src/midi_drum_track_event_encoder.sv
verif/midi_drum_track_event_encoder_checker.sv
verif/midi_drum_track_event_encoder_test.sv
